FILE: rtl/aprm_pkg.sv
// ----------------------------------------------------------------------------
// aprm_pkg
// Shared types and constants of the affine point and rectangle mapper.
// ----------------------------------------------------------------------------
package aprm_pkg;

    localparam int COEF_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_XX  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_XY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_YX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_YY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 3'd5;

    typedef enum logic [1:0] {
        MODE_POINT,
        MODE_SCALE,
        MODE_ROT
    } t_mode;

endpackage

FILE: rtl/affine_point_rect_mapper.sv
// ----------------------------------------------------------------------------
// affine_point_rect_mapper
// Maps points and rectangles through a configurable 2D affine transform.
// ----------------------------------------------------------------------------
// One beat per cycle in and out; the FRAC_BITS + 1 stage divider computes
// the bounding-box correction of rotated rectangles. The whole pipeline
// holds when a finished beat waits at the output. Coefficients and offsets
// are signed Q(32-FRAC_BITS).FRAC_BITS; the user must write them only while
// the block is empty, as the block itself does not enforce this.
module affine_point_rect_mapper #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [aprm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [aprm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_opcode,
    input  logic signed [COORD_BITS-1:0]        i_x_coord,
    input  logic signed [COORD_BITS-1:0]        i_y_coord,
    input  logic signed [COORD_BITS-1:0]        i_width_in,
    input  logic signed [COORD_BITS-1:0]        i_height_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [COORD_BITS-1:0]        o_out_x,
    output logic signed [COORD_BITS-1:0]        o_out_y,
    output logic [COORD_BITS-1:0]               o_out_width,
    output logic [COORD_BITS-1:0]               o_out_height
);

    localparam int CW  = aprm_pkg::COEF_W;
    localparam int PW  = COORD_BITS + CW + 1;
    localparam int SW  = (COORD_BITS + 36 > 64) ? 64 : COORD_BITS + 36;
    localparam int LAT = FRAC_BITS + 1;
    localparam int QW  = FRAC_BITS + 2;

    localparam logic [SW-1:0] RND_HALF = {{(SW-1){1'b0}}, 1'b1} << (FRAC_BITS-1);
    localparam logic signed [SW-1:0] S_HI =
        $signed({{(SW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}});
    localparam logic signed [SW-1:0] S_LO = ~S_HI;
    localparam logic signed [SW-1:0] U_HI =
        $signed({{(SW-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}});

    // ---------------- configuration ----------------
    logic signed [CW-1:0] r_coef_xx, r_coef_xy, r_coef_yx, r_coef_yy;
    logic signed [CW-1:0] r_off_x, r_off_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_xx <= CW'(1) << FRAC_BITS;
            r_coef_xy <= '0;
            r_coef_yx <= '0;
            r_coef_yy <= CW'(1) << FRAC_BITS;
            r_off_x   <= '0;
            r_off_y   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                aprm_pkg::CFG_COEF_XX:  r_coef_xx <= i_cfg_data;
                aprm_pkg::CFG_COEF_XY:  r_coef_xy <= i_cfg_data;
                aprm_pkg::CFG_COEF_YX:  r_coef_yx <= i_cfg_data;
                aprm_pkg::CFG_COEF_YY:  r_coef_yy <= i_cfg_data;
                aprm_pkg::CFG_OFFSET_X: r_off_x   <= i_cfg_data;
                aprm_pkg::CFG_OFFSET_Y: r_off_y   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- helpers ----------------
    function automatic logic signed [PW-1:0] mul(logic signed [CW-1:0] a,
                                                 logic signed [COORD_BITS:0] b);
        mul = a * b;
    endfunction

    function automatic logic signed [SW-1:0] ext(logic signed [PW-1:0] v);
        ext = SW'(v);
    endfunction

    function automatic logic signed [SW-1:0] rnd(logic signed [SW-1:0] v);
        logic signed [SW-1:0] t;
        t   = v + $signed(RND_HALF);
        rnd = t >>> FRAC_BITS;
    endfunction

    function automatic logic [COORD_BITS-1:0] sat_s(logic signed [SW-1:0] v);
        logic signed [SW-1:0] t;
        t     = (v > S_HI) ? S_HI : ((v < S_LO) ? S_LO : v);
        sat_s = t[COORD_BITS-1:0];
    endfunction

    function automatic logic [COORD_BITS-1:0] sat_u(logic signed [SW-1:0] v);
        logic signed [SW-1:0] t;
        t     = (v > U_HI) ? U_HI : ((v < 0) ? '0 : v);
        sat_u = t[COORD_BITS-1:0];
    endfunction

    // ---------------- pipeline control ----------------
    logic en;
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    logic r_dv [0:LAT-1];

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            o_out_valid <= 1'b0;
            for (int k = 0; k < LAT; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_dv[0] <= r_v5;
            for (int k = 1; k < LAT; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
            r_v6 <= r_dv[LAT-1];
            r_v7 <= r_v6;
            o_out_valid <= r_v7;
        end
    end

    // ---------------- stage 1: operands ----------------
    logic                         r1_op;
    logic signed [COORD_BITS:0]   r1_x, r1_y, r1_xw, r1_yh, r1_w, r1_h;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_op <= i_opcode;
            r1_x  <= (COORD_BITS+1)'(i_x_coord);
            r1_y  <= (COORD_BITS+1)'(i_y_coord);
            r1_w  <= (COORD_BITS+1)'(i_width_in);
            r1_h  <= (COORD_BITS+1)'(i_height_in);
            r1_xw <= (COORD_BITS+1)'(i_x_coord) + (COORD_BITS+1)'(i_width_in);
            r1_yh <= (COORD_BITS+1)'(i_y_coord) + (COORD_BITS+1)'(i_height_in);
        end
    end

    // ---------------- stage 2: products ----------------
    aprm_pkg::t_mode      r2_mode;
    logic signed [PW-1:0] r2_xx_x, r2_xx_xw, r2_yx_y, r2_yx_yh;
    logic signed [PW-1:0] r2_xy_x, r2_xy_xw, r2_yy_y, r2_yy_yh;
    logic signed [PW-1:0] r2_xx_w, r2_yy_h;

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (!r1_op) begin
                r2_mode <= aprm_pkg::MODE_POINT;
            end else if (r_coef_xy == '0 && r_coef_yx == '0) begin
                r2_mode <= aprm_pkg::MODE_SCALE;
            end else begin
                r2_mode <= aprm_pkg::MODE_ROT;
            end
            r2_xx_x  <= mul(r_coef_xx, r1_x);
            r2_xx_xw <= mul(r_coef_xx, r1_xw);
            r2_yx_y  <= mul(r_coef_yx, r1_y);
            r2_yx_yh <= mul(r_coef_yx, r1_yh);
            r2_xy_x  <= mul(r_coef_xy, r1_x);
            r2_xy_xw <= mul(r_coef_xy, r1_xw);
            r2_yy_y  <= mul(r_coef_yy, r1_y);
            r2_yy_yh <= mul(r_coef_yy, r1_yh);
            r2_xx_w  <= mul(r_coef_xx, r1_w);
            r2_yy_h  <= mul(r_coef_yy, r1_h);
        end
    end

    // ---------------- stage 3: corners ----------------
    aprm_pkg::t_mode      r3_mode;
    logic signed [SW-1:0] r3_cx [0:3];
    logic signed [SW-1:0] r3_cy [0:3];
    logic signed [SW-1:0] r3_pw, r3_ph;
    logic signed [SW-1:0] ox, oy;

    assign ox = SW'(r_off_x);
    assign oy = SW'(r_off_y);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_mode  <= r2_mode;
            r3_cx[0] <= ext(r2_xx_x)  + ext(r2_yx_y)  + ox;
            r3_cx[1] <= ext(r2_xx_xw) + ext(r2_yx_y)  + ox;
            r3_cx[2] <= ext(r2_xx_xw) + ext(r2_yx_yh) + ox;
            r3_cx[3] <= ext(r2_xx_x)  + ext(r2_yx_yh) + ox;
            r3_cy[0] <= ext(r2_xy_x)  + ext(r2_yy_y)  + oy;
            r3_cy[1] <= ext(r2_xy_xw) + ext(r2_yy_y)  + oy;
            r3_cy[2] <= ext(r2_xy_xw) + ext(r2_yy_yh) + oy;
            r3_cy[3] <= ext(r2_xy_x)  + ext(r2_yy_yh) + oy;
            r3_pw    <= ext(r2_xx_w);
            r3_ph    <= ext(r2_yy_h);
        end
    end

    // ---------------- stage 4: bounding box, rounding ----------------
    aprm_pkg::t_mode      r4_mode;
    logic signed [SW-1:0] r4_xmin, r4_xmax, r4_ymin, r4_ymax, r4_cx0, r4_cy0;
    logic signed [SW-1:0] r4_rx, r4_ry, r4_rw, r4_rh;
    logic signed [SW-1:0] xl0, xl1, xh0, xh1, yl0, yl1, yh0, yh1;

    always_comb begin
        xl0 = (r3_cx[1] < r3_cx[0]) ? r3_cx[1] : r3_cx[0];
        xl1 = (r3_cx[3] < r3_cx[2]) ? r3_cx[3] : r3_cx[2];
        xh0 = (r3_cx[1] > r3_cx[0]) ? r3_cx[1] : r3_cx[0];
        xh1 = (r3_cx[3] > r3_cx[2]) ? r3_cx[3] : r3_cx[2];
        yl0 = (r3_cy[1] < r3_cy[0]) ? r3_cy[1] : r3_cy[0];
        yl1 = (r3_cy[3] < r3_cy[2]) ? r3_cy[3] : r3_cy[2];
        yh0 = (r3_cy[1] > r3_cy[0]) ? r3_cy[1] : r3_cy[0];
        yh1 = (r3_cy[3] > r3_cy[2]) ? r3_cy[3] : r3_cy[2];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_mode <= r3_mode;
            r4_xmin <= (xl1 < xl0) ? xl1 : xl0;
            r4_xmax <= (xh1 > xh0) ? xh1 : xh0;
            r4_ymin <= (yl1 < yl0) ? yl1 : yl0;
            r4_ymax <= (yh1 > yh0) ? yh1 : yh0;
            r4_cx0  <= r3_cx[0];
            r4_cy0  <= r3_cy[0];
            r4_rx   <= rnd(r3_cx[0]);
            r4_ry   <= rnd(r3_cy[0]);
            r4_rw   <= rnd(r3_pw);
            r4_rh   <= rnd(r3_ph);
        end
    end

    // ---------------- stage 5: spans, numerators, flips ----------------
    aprm_pkg::t_mode      r5_mode;
    logic signed [SW-1:0] r5_xmin, r5_xmax, r5_ymin, r5_ymax;
    logic signed [SW-1:0] r5_ww, r5_hh, r5_nx0, r5_nx1, r5_ny0, r5_ny1;
    logic signed [SW-1:0] r5_px, r5_py, r5_pw, r5_ph;
    logic signed [SW-1:0] n5_px, n5_py, n5_pw, n5_ph;

    always_comb begin
        n5_px = r4_rx;
        n5_py = r4_ry;
        n5_pw = r4_rw;
        n5_ph = r4_rh;
        if (r4_rw < 0) begin
            n5_pw = -r4_rw;
            n5_px = r4_rx + r4_rw + SW'(1);
        end
        if (r4_rh < 0) begin
            n5_ph = -r4_rh;
            n5_py = r4_ry + r4_rh + SW'(1);
        end
        if (r4_mode == aprm_pkg::MODE_POINT) begin
            n5_px = r4_rx;
            n5_py = r4_ry;
            n5_pw = '0;
            n5_ph = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_mode <= r4_mode;
            r5_xmin <= r4_xmin;
            r5_xmax <= r4_xmax;
            r5_ymin <= r4_ymin;
            r5_ymax <= r4_ymax;
            r5_ww   <= r4_xmax - r4_xmin;
            r5_hh   <= r4_ymax - r4_ymin;
            r5_nx0  <= r4_xmin - r4_cx0;
            r5_nx1  <= r4_xmax - r4_cx0;
            r5_ny0  <= r4_ymin - r4_cy0;
            r5_ny1  <= r4_ymax - r4_cy0;
            r5_px   <= n5_px;
            r5_py   <= n5_py;
            r5_pw   <= n5_pw;
            r5_ph   <= n5_ph;
        end
    end

    // ---------------- box correction dividers ----------------
    logic signed [QW-1:0] q_x0, q_x1, q_y0, q_y1;

    aprm_ratio #(.W(SW), .FRAC_BITS(FRAC_BITS)) u_div_x0 (
        .i_clk(i_clk), .i_en(en), .i_num(r5_nx0), .i_den(r5_ww), .o_q(q_x0)
    );
    aprm_ratio #(.W(SW), .FRAC_BITS(FRAC_BITS)) u_div_x1 (
        .i_clk(i_clk), .i_en(en), .i_num(r5_nx1), .i_den(r5_ww), .o_q(q_x1)
    );
    aprm_ratio #(.W(SW), .FRAC_BITS(FRAC_BITS)) u_div_y0 (
        .i_clk(i_clk), .i_en(en), .i_num(r5_ny0), .i_den(r5_hh), .o_q(q_y0)
    );
    aprm_ratio #(.W(SW), .FRAC_BITS(FRAC_BITS)) u_div_y1 (
        .i_clk(i_clk), .i_en(en), .i_num(r5_ny1), .i_den(r5_hh), .o_q(q_y1)
    );

    // side data delayed alongside the dividers
    aprm_pkg::t_mode      r_dmode [0:LAT-1];
    logic signed [SW-1:0] r_dxmin [0:LAT-1];
    logic signed [SW-1:0] r_dxmax [0:LAT-1];
    logic signed [SW-1:0] r_dymin [0:LAT-1];
    logic signed [SW-1:0] r_dymax [0:LAT-1];
    logic signed [SW-1:0] r_dpx   [0:LAT-1];
    logic signed [SW-1:0] r_dpy   [0:LAT-1];
    logic signed [SW-1:0] r_dpw   [0:LAT-1];
    logic signed [SW-1:0] r_dph   [0:LAT-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dmode[0] <= r5_mode;
            r_dxmin[0] <= r5_xmin;
            r_dxmax[0] <= r5_xmax;
            r_dymin[0] <= r5_ymin;
            r_dymax[0] <= r5_ymax;
            r_dpx[0]   <= r5_px;
            r_dpy[0]   <= r5_py;
            r_dpw[0]   <= r5_pw;
            r_dph[0]   <= r5_ph;
            for (int k = 1; k < LAT; k++) begin
                r_dmode[k] <= r_dmode[k-1];
                r_dxmin[k] <= r_dxmin[k-1];
                r_dxmax[k] <= r_dxmax[k-1];
                r_dymin[k] <= r_dymin[k-1];
                r_dymax[k] <= r_dymax[k-1];
                r_dpx[k]   <= r_dpx[k-1];
                r_dpy[k]   <= r_dpy[k-1];
                r_dpw[k]   <= r_dpw[k-1];
                r_dph[k]   <= r_dph[k-1];
            end
        end
    end

    // ---------------- stage 6: apply correction ----------------
    aprm_pkg::t_mode      r6_mode;
    logic signed [SW-1:0] r6_xa, r6_xb, r6_ya, r6_yb;
    logic signed [SW-1:0] r6_px, r6_py, r6_pw, r6_ph;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_mode <= r_dmode[LAT-1];
            r6_xa   <= r_dxmin[LAT-1] - SW'(q_x0);
            r6_xb   <= r_dxmax[LAT-1] - SW'(q_x1);
            r6_ya   <= r_dymin[LAT-1] - SW'(q_y0);
            r6_yb   <= r_dymax[LAT-1] - SW'(q_y1);
            r6_px   <= r_dpx[LAT-1];
            r6_py   <= r_dpy[LAT-1];
            r6_pw   <= r_dpw[LAT-1];
            r6_ph   <= r_dph[LAT-1];
        end
    end

    // ---------------- stage 7: rounding ----------------
    aprm_pkg::t_mode      r7_mode;
    logic signed [SW-1:0] r7_xa, r7_xb, r7_ya, r7_yb;
    logic signed [SW-1:0] r7_px, r7_py, r7_pw, r7_ph;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_mode <= r6_mode;
            r7_xa   <= rnd(r6_xa);
            r7_xb   <= rnd(r6_xb);
            r7_ya   <= rnd(r6_ya);
            r7_yb   <= rnd(r6_yb);
            r7_px   <= r6_px;
            r7_py   <= r6_py;
            r7_pw   <= r6_pw;
            r7_ph   <= r6_ph;
        end
    end

    // ---------------- stage 8: select and saturate ----------------
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r7_mode == aprm_pkg::MODE_ROT) begin
                o_out_x      <= sat_s(r7_xa);
                o_out_y      <= sat_s(r7_ya);
                o_out_width  <= sat_u(r7_xb - r7_xa + SW'(1));
                o_out_height <= sat_u(r7_yb - r7_ya + SW'(1));
            end else begin
                o_out_x      <= sat_s(r7_px);
                o_out_y      <= sat_s(r7_py);
                o_out_width  <= sat_u(r7_pw);
                o_out_height <= sat_u(r7_ph);
            end
        end
    end

endmodule

FILE: rtl/aprm_ratio.sv
// ----------------------------------------------------------------------------
// aprm_ratio
// Pipelined restoring divider: num / den with FRAC_BITS fraction bits,
// truncated toward zero, for |num| <= den. Zero when den <= 0.
// Its stages advance only while i_en is high.
// ----------------------------------------------------------------------------
module aprm_ratio #(
    parameter int W         = 52,
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [W-1:0]    i_num,
    input  logic signed [W-1:0]    i_den,
    output logic signed [FRAC_BITS+1:0] o_q
);

    localparam int QW = FRAC_BITS + 1;

    logic [W-1:0]  r_rem  [0:FRAC_BITS];
    logic [W-1:0]  r_d    [0:FRAC_BITS];
    logic [QW-1:0] r_q    [0:FRAC_BITS];
    logic          r_neg  [0:FRAC_BITS];
    logic          r_zero [0:FRAC_BITS];

    logic [W-1:0]  n_rem  [1:FRAC_BITS];
    logic          n_ge   [1:FRAC_BITS];

    logic [W-1:0]  mag;
    logic [W-1:0]  mag_c;
    logic          q0;

    always_comb begin
        mag   = i_num[W-1] ? W'(-i_num) : W'(i_num);
        mag_c = (mag > W'(i_den)) ? W'(i_den) : mag;
        q0    = (mag_c >= W'(i_den));
        for (int k = 1; k <= FRAC_BITS; k++) begin
            n_ge[k]  = ({r_rem[k-1][W-2:0], 1'b0} >= r_d[k-1]);
            n_rem[k] = n_ge[k] ? {r_rem[k-1][W-2:0], 1'b0} - r_d[k-1]
                               : {r_rem[k-1][W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= q0 ? '0 : mag_c;
            r_d[0]    <= W'(i_den);
            r_q[0]    <= {{(QW-1){1'b0}}, q0};
            r_neg[0]  <= i_num[W-1];
            r_zero[0] <= i_den[W-1] | (i_den == '0);
            for (int k = 1; k <= FRAC_BITS; k++) begin
                r_rem[k]  <= n_rem[k];
                r_d[k]    <= r_d[k-1];
                r_q[k]    <= {r_q[k-1][QW-2:0], n_ge[k]};
                r_neg[k]  <= r_neg[k-1];
                r_zero[k] <= r_zero[k-1];
            end
        end
    end

    always_comb begin
        if (r_zero[FRAC_BITS]) begin
            o_q = '0;
        end else if (r_neg[FRAC_BITS]) begin
            o_q = -$signed({1'b0, r_q[FRAC_BITS]});
        end else begin
            o_q = $signed({1'b0, r_q[FRAC_BITS]});
        end
    end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams points and rectangles through the affine mapper under several
// transforms, with random idling on both handshakes, and checks every output
// beat field by field against a behavioral model of the mapping.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CB = 16;
    localparam int FB = 16;
    localparam int LATENCY = FB + 9;
    localparam int STALL_LIMIT = 20000;
    localparam logic OP_POINT = 1'b0;
    localparam logic OP_RECT  = 1'b1;

    typedef struct packed {
        logic                 op;
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic signed [CB-1:0] w;
        logic signed [CB-1:0] h;
    } t_shape;

    typedef struct packed {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic [CB-1:0]        w;
        logic [CB-1:0]        h;
    } t_box;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [aprm_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [aprm_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic i_opcode = 1'b0;
    logic signed [CB-1:0] i_x_coord = '0, i_y_coord = '0, i_width_in = '0, i_height_in = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [CB-1:0] o_out_x, o_out_y;
    logic [CB-1:0] o_out_width, o_out_height;

    // beat accepted at last rising edge
    logic o_in_ready_seen = 1'b0;

    affine_point_rect_mapper #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (.*);

    always #10 i_clk = ~i_clk;

    longint m_xx, m_xy, m_yx, m_yy, m_dx, m_dy;

    t_shape pending_shapes[$];
    t_box   expected_boxes[$];
    int send_idle_pct = 0, recv_idle_pct = 0;
    bit recv_hold = 1'b0;
    int mismatches = 0;
    int stall_cycles = 0;

    function automatic longint floor_shr(longint v);
        return v >>> FB;
    endfunction

    function automatic longint round_half_up(longint v);
        return floor_shr(v + (64'sd1 <<< (FB - 1)));
    endfunction

    function automatic longint frac_ratio(longint num, longint den);
        longint unsigned mag, rem, q;
        if (den <= 0) return 0;
        mag = num < 0 ? -num : num;
        if (mag > den) mag = den;
        q = (mag >= den) ? 64'd1 : 64'd0;
        rem = mag - (q != 0 ? den : 64'sd0);
        for (int i = 0; i < FB; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den) begin
                rem = rem - den;
                q = q | 64'd1;
            end
        end
        return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp_signed(longint v);
        longint hi = (64'sd1 <<< (CB - 1)) - 1;
        return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
    endfunction

    function automatic longint clamp_unsigned(longint v);
        longint hi = (64'sd1 <<< CB) - 1;
        return v > hi ? hi : (v < 0 ? 0 : v);
    endfunction

    function automatic t_box map_shape(t_shape s);
        longint x, y, w, h, rx, ry, rw, rh;
        longint cx[4], cy[4], px[4], py[4];
        longint xmin, xmax, ymin, ymax, ww, hh;
        t_box b;
        x = $signed(s.x); y = $signed(s.y); w = $signed(s.w); h = $signed(s.h);
        if (s.op == OP_POINT) begin
            rx = round_half_up(m_xx * x + m_yx * y + m_dx);
            ry = round_half_up(m_xy * x + m_yy * y + m_dy);
            rw = 0; rh = 0;
        end else if (m_xy == 0 && m_yx == 0) begin
            rx = round_half_up(m_xx * x + m_dx);
            ry = round_half_up(m_yy * y + m_dy);
            rw = round_half_up(m_xx * w);
            rh = round_half_up(m_yy * h);
            if (rw < 0) begin
                rw = -rw;
                rx = rx - (rw - 1);
            end
            if (rh < 0) begin
                rh = -rh;
                ry = ry - (rh - 1);
            end
        end else begin
            px = '{x, x + w, x + w, x};
            py = '{y, y, y + h, y + h};
            for (int i = 0; i < 4; i++) begin
                cx[i] = m_xx * px[i] + m_yx * py[i] + m_dx;
                cy[i] = m_xy * px[i] + m_yy * py[i] + m_dy;
            end
            xmin = cx[0]; xmax = cx[0]; ymin = cy[0]; ymax = cy[0];
            for (int i = 1; i < 4; i++) begin
                if (cx[i] < xmin) xmin = cx[i];
                if (cx[i] > xmax) xmax = cx[i];
                if (cy[i] < ymin) ymin = cy[i];
                if (cy[i] > ymax) ymax = cy[i];
            end
            ww = xmax - xmin;
            hh = ymax - ymin;
            xmin = xmin - frac_ratio(xmin - cx[0], ww);
            xmax = xmax - frac_ratio(xmax - cx[0], ww);
            ymin = ymin - frac_ratio(ymin - cy[0], hh);
            ymax = ymax - frac_ratio(ymax - cy[0], hh);
            rx = round_half_up(xmin);
            rw = round_half_up(xmax) - rx + 1;
            ry = round_half_up(ymin);
            rh = round_half_up(ymax) - ry + 1;
        end
        b.x = CB'(clamp_signed(rx));
        b.y = CB'(clamp_signed(ry));
        b.w = CB'(clamp_unsigned(rw));
        b.h = CB'(clamp_unsigned(rh));
        return b;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || o_in_ready_seen) begin
                if (pending_shapes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_shape s;
                    s = pending_shapes.pop_front();
                    i_opcode <= s.op;
                    i_x_coord <= s.x;
                    i_y_coord <= s.y;
                    i_width_in <= s.w;
                    i_height_in <= s.h;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        bit any_beat;
        any_beat = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                t_shape s;
                s = '{i_opcode, i_x_coord, i_y_coord, i_width_in, i_height_in};
                expected_boxes.push_back(map_shape(s));
                any_beat = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                any_beat = 1'b1;
                if (expected_boxes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected output beat");
                end else begin
                    t_box e;
                    e = expected_boxes.pop_front();
                    if (e.x !== o_out_x || e.y !== o_out_y ||
                        e.w !== o_out_width || e.h !== o_out_height) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch exp x=%0d y=%0d w=%0d h=%0d ",
                                      "got x=%0d y=%0d w=%0d h=%0d"},
                                e.x, e.y, e.w, e.h, o_out_x, o_out_y,
                                o_out_width, o_out_height);
                    end
                end
            end
            stall_cycles <= any_beat ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
        o_in_ready_seen <= i_rst_n && i_in_valid && o_in_ready;
    end

    task automatic write_reg(logic [aprm_pkg::CFG_IDX_W-1:0] idx, longint v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v[31:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            aprm_pkg::CFG_COEF_XX:  m_xx = longint'($signed(v[31:0]));
            aprm_pkg::CFG_COEF_XY:  m_xy = longint'($signed(v[31:0]));
            aprm_pkg::CFG_COEF_YX:  m_yx = longint'($signed(v[31:0]));
            aprm_pkg::CFG_COEF_YY:  m_yy = longint'($signed(v[31:0]));
            aprm_pkg::CFG_OFFSET_X: m_dx = longint'($signed(v[31:0]));
            aprm_pkg::CFG_OFFSET_Y: m_dy = longint'($signed(v[31:0]));
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_shapes.size() > 0 || i_in_valid || expected_boxes.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic set_matrix(longint xx, longint xy, longint yx, longint yy,
                              longint dx, longint dy);
        write_reg(aprm_pkg::CFG_COEF_XX, xx);
        write_reg(aprm_pkg::CFG_COEF_XY, xy);
        write_reg(aprm_pkg::CFG_COEF_YX, yx);
        write_reg(aprm_pkg::CFG_COEF_YY, yy);
        write_reg(aprm_pkg::CFG_OFFSET_X, dx);
        write_reg(aprm_pkg::CFG_OFFSET_Y, dy);
    endtask

    function automatic logic signed [CB-1:0] rand_coord(int mode);
        case (mode)
            0: return CB'($urandom_range(40) - 20);
            1: return CB'($urandom_range(1000) - 500);
            default: return CB'($urandom);
        endcase
    endfunction

    task automatic queue_random(int n, int mode);
        t_shape s;
        for (int i = 0; i < n; i++) begin
            s.op = 1'($urandom_range(1));
            s.x = rand_coord($urandom_range(2) == 2 ? 2 : mode);
            s.y = rand_coord($urandom_range(2) == 2 ? 2 : mode);
            s.w = rand_coord($urandom_range(3) == 3 ? 2 : mode);
            s.h = rand_coord($urandom_range(3) == 3 ? 2 : mode);
            pending_shapes.push_back(s);
        end
    endtask

    function automatic longint rand_coef(int mode);
        case (mode)
            0: return longint'($urandom_range(8 * 65536)) - 4 * 65536;
            1: return longint'($urandom_range(2 * 65536)) - 65536;
            default: return longint'($signed($urandom));
        endcase
    endfunction

    initial begin
        m_xx = 65536; m_xy = 0; m_yx = 0; m_yy = 65536; m_dx = 0; m_dy = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes under identity, then flipping scale, then rotation, then extreme coefficients
        pending_shapes.push_back('{OP_POINT, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
        pending_shapes.push_back('{OP_POINT, 16'sh8000, 16'sh7fff, 16'sh0, 16'sh0});
        pending_shapes.push_back('{OP_RECT, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
        pending_shapes.push_back('{OP_RECT, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
        pending_shapes.push_back('{OP_RECT, 16'sd5, 16'sd5, -16'sd3, -16'sd4});
        pending_shapes.push_back('{OP_RECT, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
        drain();
        set_matrix(-32768, 0, 0, 98304, 32768, -32768);
        pending_shapes.push_back('{OP_RECT, 16'sd7, -16'sd3, 16'sd9, -16'sd5});
        pending_shapes.push_back('{OP_POINT, 16'sd1, 16'sd1, 16'sd0, 16'sd0});
        pending_shapes.push_back('{OP_POINT, -16'sd1, -16'sd1, 16'sd0, 16'sd0});
        drain();
        set_matrix(46341, 46341, -46341, 46341, 0, 0);
        pending_shapes.push_back('{OP_RECT, 16'sd10, 16'sd20, 16'sd30, 16'sd40});
        pending_shapes.push_back('{OP_RECT, 16'sd10, 16'sd20, 16'sd0, 16'sd0});
        pending_shapes.push_back('{OP_RECT, -16'sd10, 16'sd5, -16'sd8, 16'sd0});
        pending_shapes.push_back('{OP_POINT, 16'sh7fff, 16'sh7fff, 16'sd0, 16'sd0});
        drain();
        set_matrix(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                   32'sh7fffffff, 32'sh80000000);
        pending_shapes.push_back('{OP_RECT, 16'sd1, 16'sd1, 16'sd1, 16'sd1});
        pending_shapes.push_back('{OP_POINT, 16'sh8000, 16'sh7fff, 16'sd0, 16'sd0});
        drain();

        // random phases
        for (int ph = 0; ph < 9; ph++) begin
            int mode;
            mode = ph % 3;
            if (ph < 3) begin
                send_idle_pct = 14; recv_idle_pct = 86;
            end else if (ph < 6) begin
                send_idle_pct = 86; recv_idle_pct = 14;
            end else begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            if (ph % 2 == 0)
                set_matrix(rand_coef(mode), 0, 0, rand_coef(mode),
                           rand_coef(mode), rand_coef(mode));
            else
                set_matrix(rand_coef(mode), rand_coef(mode), rand_coef(mode),
                           rand_coef(mode), rand_coef(mode), rand_coef(mode));
            queue_random(95, mode);
            if (ph == 7) begin
                recv_hold = 1'b1;
                repeat (200) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
